// ===== design/lpd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpd_pkg: shared types and constants of the LUT pixel descrambler
// Command codes, binning geometry and the result record.
// ----------------------------------------------------------------------------
package lpd_pkg;

	localparam int DATA_W = 16;
	// LUT address width wide enough for binned addresses and range checks
	localparam int LUT_ADDR_W = 17;

	// binned gather geometry: pixels per half batch, LUT base of the upper half
	localparam int BIN_HALF_PIX   = 7200;
	localparam int BIN_UPPER_BASE = 43200;

	// output queue
	localparam int OUT_FIFO_DEPTH = 4;
	localparam int OUT_FIFO_PTR_W = $clog2(OUT_FIFO_DEPTH);
	localparam int OUT_FIFO_CNT_W = $clog2(OUT_FIFO_DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_WR_LUT = 2'd0,
		CMD_WR_RAW = 2'd1,
		CMD_RD_PIX = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [DATA_W-1:0] pixel;
		logic [DATA_W-1:0] pixel_number;
		logic              bad_index;
	} result_t;

endpackage
`default_nettype wire

// ===== design/lpd_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpd_ram: simple dual-port synchronous RAM
// One write port, one read port, registered read data (read-first).
// ----------------------------------------------------------------------------
module lpd_ram #(
	parameter int DEPTH  = 65536,
	parameter int ADDR_W = 16,
	parameter int DATA_W = 16
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// write and read in the same edge: read returns the old contents
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== design/lpd_out_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpd_out_fifo: small result queue in front of the output port
// Absorbs results still in the read pipeline while the sink stalls.
// ----------------------------------------------------------------------------
module lpd_out_fifo
	import lpd_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	input  wire result_t                   push_data,
	input  wire logic                      pop,
	output logic                           not_empty,
	output result_t                        head,
	output logic      [OUT_FIFO_CNT_W-1:0] count
);

	result_t                   entry_q [OUT_FIFO_DEPTH];
	logic [OUT_FIFO_PTR_W-1:0] wr_ptr_q;
	logic [OUT_FIFO_PTR_W-1:0] rd_ptr_q;
	logic [OUT_FIFO_CNT_W-1:0] count_q;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// payload storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];
	assign count     = count_q;

endmodule
`default_nettype wire

// ===== design/lut_pixel_descrambler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lut_pixel_descrambler: gathers camera pixels through a lookup table
// LUT and raw sample memories, a two-step read pipeline and a result queue.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  in        in_valid / in_stall   cmd, index, value
//  out       out_valid / out_stall pixel, pixel_number, bad_index
//  config    bin_mode_we           bin_mode_wdata
//
// LUT and raw writes never stall.
// A pixel read passes LUT read, raw read and the result queue to the output.
// Reads issue one per cycle; at most four are outstanding (pipeline plus
// queue), so in_stall rises on a read only when the result queue is backed up.
// Reset clears control state only; memory contents are undefined until written.
// ----------------------------------------------------------------------------
module lut_pixel_descrambler
	import lpd_pkg::*;
#(
	parameter int OUT_PIXELS  = 57600,
	parameter int RAW_SAMPLES = 65536
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              bin_mode_we,
	input  wire logic              bin_mode_wdata,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        cmd,
	input  wire logic [DATA_W-1:0] index,
	input  wire logic [DATA_W-1:0] value,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [DATA_W-1:0] pixel,
	output logic      [DATA_W-1:0] pixel_number,
	output logic                   bad_index
);

	localparam int LUT_AW = $clog2(OUT_PIXELS);
	localparam int RAW_AW = $clog2(RAW_SAMPLES);

	logic                      bin_mode_q;
	logic                      in_accept;
	logic                      is_read;
	logic                      rd_allow;
	logic [LUT_ADDR_W-1:0]     index_x;
	logic [LUT_ADDR_W-1:0]     lut_addr;
	logic                      lut_zero;
	logic                      req_bad;
	logic                      lut_we;
	logic                      raw_we;
	logic                      lut_re;
	logic [DATA_W-1:0]         lut_rdata;
	logic [DATA_W-1:0]         raw_rdata;
	logic                      raw_beyond;
	logic                      valid_s1;
	logic                      zero_s1;
	logic                      bad_s1;
	logic [DATA_W-1:0]         num_s1;
	logic                      valid_s2;
	logic                      zero_s2;
	logic                      bad_s2;
	logic [DATA_W-1:0]         num_s2;
	result_t                   res_s2;
	result_t                   head;
	logic                      fifo_pop;
	logic [OUT_FIFO_CNT_W-1:0] fifo_count;
	logic [OUT_FIFO_CNT_W-1:0] outstanding;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_mode_q <= 1'b0;
		end else if (bin_mode_we) begin
			bin_mode_q <= bin_mode_wdata;
		end
	end

	// input handshake: only reads wait, and only for queue room
	assign is_read     = (cmd == CMD_RD_PIX);
	assign outstanding = fifo_count + OUT_FIFO_CNT_W'(valid_s1) + OUT_FIFO_CNT_W'(valid_s2);
	assign rd_allow    = (outstanding < OUT_FIFO_CNT_W'(OUT_FIFO_DEPTH));
	assign in_stall    = is_read && !rd_allow;
	assign in_accept   = in_valid && !in_stall;

	// LUT address of the requested pixel
	assign index_x = {1'b0, index};
	always_comb begin
		req_bad  = (index_x >= LUT_ADDR_W'(OUT_PIXELS));
		lut_addr = index_x;
		lut_zero = 1'b0;
		if (bin_mode_q) begin
			if (index_x < LUT_ADDR_W'(BIN_HALF_PIX)) begin
				lut_addr = {index, 1'b0};
			end else if (index_x < LUT_ADDR_W'(2 * BIN_HALF_PIX)) begin
				lut_addr = {(index - DATA_W'(BIN_HALF_PIX)), 1'b0} +
					LUT_ADDR_W'(BIN_UPPER_BASE);
			end else begin
				lut_zero = 1'b1;
			end
		end
		if (lut_addr >= LUT_ADDR_W'(OUT_PIXELS)) begin
			lut_zero = 1'b1;
		end
		if (req_bad) begin
			lut_zero = 1'b1;
		end
	end

	assign lut_we = in_accept && (cmd == CMD_WR_LUT) && !req_bad;
	assign raw_we = in_accept && (cmd == CMD_WR_RAW) &&
		(index_x < LUT_ADDR_W'(RAW_SAMPLES));
	assign lut_re = in_accept && is_read && !lut_zero;

	lpd_ram #(
		.DEPTH  (OUT_PIXELS),
		.ADDR_W (LUT_AW),
		.DATA_W (DATA_W)
	) u_lut_ram (
		.clk   (clk),
		.we    (lut_we),
		.waddr (index[LUT_AW-1:0]),
		.wdata (value),
		.re    (lut_re),
		.raddr (lut_addr[LUT_AW-1:0]),
		.rdata (lut_rdata)
	);

	// stage 1: LUT data returns, raw sample read issues
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_accept && is_read;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		zero_s1 <= lut_zero;
		bad_s1  <= req_bad;
		num_s1  <= index;
		zero_s2 <= zero_s1 || raw_beyond;
		bad_s2  <= bad_s1;
		num_s2  <= num_s1;
	end

	assign raw_beyond = ({1'b0, lut_rdata} >= LUT_ADDR_W'(RAW_SAMPLES));

	lpd_ram #(
		.DEPTH  (RAW_SAMPLES),
		.ADDR_W (RAW_AW),
		.DATA_W (DATA_W)
	) u_raw_ram (
		.clk   (clk),
		.we    (raw_we),
		.waddr (index[RAW_AW-1:0]),
		.wdata (value),
		.re    (valid_s1 && !zero_s1 && !raw_beyond),
		.raddr (lut_rdata[RAW_AW-1:0]),
		.rdata (raw_rdata)
	);

	// stage 2: raw sample returns, result goes into the queue
	always_comb begin
		res_s2.pixel        = zero_s2 ? '0 : raw_rdata;
		res_s2.pixel_number = num_s2;
		res_s2.bad_index    = bad_s2;
	end

	assign fifo_pop = out_valid && !out_stall;

	lpd_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s2),
		.push_data (res_s2),
		.pop       (fifo_pop),
		.not_empty (out_valid),
		.head      (head),
		.count     (fifo_count)
	);

	assign pixel        = head.pixel;
	assign pixel_number = head.pixel_number;
	assign bad_index    = head.bad_index;

endmodule
`default_nettype wire
